### rtl/periodic_resource_admission_test_assert.svh
// Assertion macros used by the checker file of the admission block.
`ifndef PERIODIC_RESOURCE_ADMISSION_TEST_ASSERT_SVH
`define PERIODIC_RESOURCE_ADMISSION_TEST_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PRAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("admission block assertion failed");

// Next-cycle implication, disabled while in reset.
`define PRAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("admission block assertion failed");

`endif

### rtl/prat_pkg.sv
// ----------------------------------------------------------------------------
// prat_pkg
// Types and constants of the periodic resource admission block.
// ----------------------------------------------------------------------------
package prat_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IBITS     = 30;

  localparam logic [16:0] ONE_Q       = 17'h1_0000;
  localparam logic [7:0]  TASK_LIMIT  = 8'd255;
  localparam logic [23:0] SUM_MAX     = 24'hFF_FFFF;
  localparam logic [15:0] PERIOD_NONE = 16'hFFFF;
  localparam logic [31:0] IONE        = 32'h4000_0000;
  localparam logic [31:0] HI_INIT     = 32'h8000_0001;

  // divider step counts
  localparam logic [5:0] K_STEPS = 6'd18;
  localparam logic [5:0] R_STEPS = 6'd30;
  localparam logic [5:0] H_STEPS = 6'd33;

  localparam logic [1:0] CFG_PERIOD   = 2'd0;
  localparam logic [1:0] CFG_CAPACITY = 2'd1;

  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_ASSIGN = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_K_SETUP,
    ST_K_DIV,
    ST_R_SETUP,
    ST_R_INT,
    ST_R_DIV,
    ST_S_CHECK,
    ST_POW,
    ST_S_UPD,
    ST_B_MUL1,
    ST_B_MUL2,
    ST_FIN,
    ST_H_SETUP,
    ST_H_DIV,
    ST_H_FIN,
    ST_UPDATE,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_K_SETUP,
    CMD_DIV_STEP,
    CMD_R_SETUP,
    CMD_R_INT,
    CMD_S_INIT,
    CMD_POW_STEP,
    CMD_S_UPD,
    CMD_B_MUL1,
    CMD_B_MUL2,
    CMD_FIN,
    CMD_H_SETUP,
    CMD_H_FIN,
    CMD_UPDATE
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
    logic    res_load;
  } dp_ctrl_t;

  typedef struct packed {
    op_e  op;
    logic harm;
    logic ratio_bad;
    logic search_done;
    logic pow_done;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/periodic_resource_admission_test.sv
// ----------------------------------------------------------------------------
// periodic_resource_admission_test
// Admission unit for one periodic resource (rate-monotonic utilization bound).
// ----------------------------------------------------------------------------
// One item at a time. Clear, no-op and plain assign go straight to the update;
// a harmonic check or assign runs the 33-step serial divider.
// A normal check runs a root search of S steps (S up to 31); each step is
// a square-and-multiply of length L = bit length of task_count+1 (1..9). The
// result register lets the next item be accepted while a result waits to
// be taken. Configuration writes are always taken (cfg_ready_o is tied high).
module periodic_resource_admission_test (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [16:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           operation_i,
  input  logic                 harmonic_mode_i,
  input  logic [15:0]          task_period_i,
  input  logic [16:0]          task_utilization_i,
  input  logic [17:0]          harmonicity_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 admitted_o,
  output logic signed [24:0]   bound_margin_o,
  output logic [7:0]           task_count_o,
  output logic [15:0]          min_period_o,
  output logic [23:0]          utilization_sum_o,
  output logic [23:0]          harmonic_sum_o
);

  prat_pkg::dp_ctrl_t   ctrl;
  prat_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  prat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  prat_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .operation_i        (operation_i),
    .harmonic_mode_i    (harmonic_mode_i),
    .task_period_i      (task_period_i),
    .task_utilization_i (task_utilization_i),
    .harmonicity_i      (harmonicity_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .admitted_o         (admitted_o),
    .bound_margin_o     (bound_margin_o),
    .task_count_o       (task_count_o),
    .min_period_o       (min_period_o),
    .utilization_sum_o  (utilization_sum_o),
    .harmonic_sum_o     (harmonic_sum_o),
    .ctrl_i             (ctrl),
    .status_o           (status)
  );

endmodule

### rtl/prat_ctrl.sv
// ----------------------------------------------------------------------------
// prat_ctrl
// Sequencer: walks one item through the K division, ratio division, root
// search and bound, or through the harmonic division, or to the update.
// ----------------------------------------------------------------------------
module prat_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  prat_pkg::dp_status_t status_i,
  output prat_pkg::dp_ctrl_t   ctrl_o
);

  prat_pkg::state_e state_q, state_d;
  logic [5:0]       cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prat_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      prat_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = prat_pkg::ST_DECODE;
      end
      prat_pkg::ST_DECODE: begin
        priority if (status_i.op == prat_pkg::OP_CHECK && !status_i.harm) begin
          state_d = prat_pkg::ST_K_SETUP;
        end else if ((status_i.op == prat_pkg::OP_CHECK ||
                      status_i.op == prat_pkg::OP_ASSIGN) && status_i.harm) begin
          state_d = prat_pkg::ST_H_SETUP;
        end else begin
          state_d = prat_pkg::ST_UPDATE;
        end
      end
      prat_pkg::ST_K_SETUP: begin
        state_d = prat_pkg::ST_K_DIV;
        cnt_d   = prat_pkg::K_STEPS - 6'd1;
      end
      prat_pkg::ST_K_DIV: begin
        if (cnt_q == '0) state_d = prat_pkg::ST_R_SETUP;
        else cnt_d = cnt_q - 6'd1;
      end
      prat_pkg::ST_R_SETUP: state_d = prat_pkg::ST_R_INT;
      prat_pkg::ST_R_INT: begin
        if (status_i.ratio_bad) begin
          state_d = prat_pkg::ST_FIN;
        end else begin
          state_d = prat_pkg::ST_R_DIV;
          cnt_d   = prat_pkg::R_STEPS - 6'd1;
        end
      end
      prat_pkg::ST_R_DIV: begin
        if (cnt_q == '0) state_d = prat_pkg::ST_S_CHECK;
        else cnt_d = cnt_q - 6'd1;
      end
      prat_pkg::ST_S_CHECK: begin
        state_d = status_i.search_done ? prat_pkg::ST_B_MUL1 : prat_pkg::ST_POW;
      end
      prat_pkg::ST_POW: begin
        if (status_i.pow_done) state_d = prat_pkg::ST_S_UPD;
      end
      prat_pkg::ST_S_UPD:  state_d = prat_pkg::ST_S_CHECK;
      prat_pkg::ST_B_MUL1: state_d = prat_pkg::ST_B_MUL2;
      prat_pkg::ST_B_MUL2: state_d = prat_pkg::ST_FIN;
      prat_pkg::ST_FIN:    state_d = prat_pkg::ST_DONE;
      prat_pkg::ST_H_SETUP: begin
        state_d = prat_pkg::ST_H_DIV;
        cnt_d   = prat_pkg::H_STEPS - 6'd1;
      end
      prat_pkg::ST_H_DIV: begin
        if (cnt_q == '0) state_d = prat_pkg::ST_H_FIN;
        else cnt_d = cnt_q - 6'd1;
      end
      prat_pkg::ST_H_FIN: begin
        state_d = (status_i.op == prat_pkg::OP_CHECK) ? prat_pkg::ST_FIN
                                                      : prat_pkg::ST_UPDATE;
      end
      prat_pkg::ST_UPDATE: state_d = prat_pkg::ST_DONE;
      prat_pkg::ST_DONE: begin
        if (status_i.out_free) state_d = prat_pkg::ST_IDLE;
      end
      default: state_d = prat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.cmd      = prat_pkg::CMD_NONE;
    ctrl_o.res_load = 1'b0;
    in_stall_o      = (state_q != prat_pkg::ST_IDLE);
    unique case (state_q)
      prat_pkg::ST_IDLE:    if (in_valid_i) ctrl_o.cmd = prat_pkg::CMD_LOAD;
      prat_pkg::ST_K_SETUP: ctrl_o.cmd = prat_pkg::CMD_K_SETUP;
      prat_pkg::ST_K_DIV,
      prat_pkg::ST_R_DIV,
      prat_pkg::ST_H_DIV:   ctrl_o.cmd = prat_pkg::CMD_DIV_STEP;
      prat_pkg::ST_R_SETUP: ctrl_o.cmd = prat_pkg::CMD_R_SETUP;
      prat_pkg::ST_R_INT:   ctrl_o.cmd = prat_pkg::CMD_R_INT;
      prat_pkg::ST_S_CHECK: begin
        if (!status_i.search_done) ctrl_o.cmd = prat_pkg::CMD_S_INIT;
      end
      prat_pkg::ST_POW: begin
        if (!status_i.pow_done) ctrl_o.cmd = prat_pkg::CMD_POW_STEP;
      end
      prat_pkg::ST_S_UPD:   ctrl_o.cmd = prat_pkg::CMD_S_UPD;
      prat_pkg::ST_B_MUL1:  ctrl_o.cmd = prat_pkg::CMD_B_MUL1;
      prat_pkg::ST_B_MUL2:  ctrl_o.cmd = prat_pkg::CMD_B_MUL2;
      prat_pkg::ST_FIN:     ctrl_o.cmd = prat_pkg::CMD_FIN;
      prat_pkg::ST_H_SETUP: ctrl_o.cmd = prat_pkg::CMD_H_SETUP;
      prat_pkg::ST_H_FIN:   ctrl_o.cmd = prat_pkg::CMD_H_FIN;
      prat_pkg::ST_UPDATE:  ctrl_o.cmd = prat_pkg::CMD_UPDATE;
      prat_pkg::ST_DONE:    ctrl_o.res_load = status_i.out_free;
      default:              ctrl_o.cmd = prat_pkg::CMD_NONE;
    endcase
  end

endmodule

### rtl/prat_dp.sv
// ----------------------------------------------------------------------------
// prat_dp
// Datapath: configuration and task state, a shared restoring divider, the
// power unit of the root search, the bound multiplier and the result register.
// ----------------------------------------------------------------------------
module prat_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [16:0]          cfg_data_i,
  input  logic [1:0]           operation_i,
  input  logic                 harmonic_mode_i,
  input  logic [15:0]          task_period_i,
  input  logic [16:0]          task_utilization_i,
  input  logic [17:0]          harmonicity_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic                 admitted_o,
  output logic signed [24:0]   bound_margin_o,
  output logic [7:0]           task_count_o,
  output logic [15:0]          min_period_o,
  output logic [23:0]          utilization_sum_o,
  output logic [23:0]          harmonic_sum_o,
  input  prat_pkg::dp_ctrl_t   ctrl_i,
  output prat_pkg::dp_status_t status_o
);

  // Q.30 product, truncated and saturated to 32 bits
  function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return (p[63:62] != 2'b00) ? 32'hFFFF_FFFF : p[61:30];
  endfunction

  // configuration and task state
  logic [15:0] period_q;
  logic [16:0] cap_q;
  logic [7:0]  count_q;
  logic [15:0] minp_q;
  logic [23:0] usum_q, hsum_q;
  logic        out_valid_q;

  // latched item
  prat_pkg::op_e op_q;
  logic          harm_q;
  logic [15:0]   tp_q;
  logic [16:0]   u_q;
  logic [17:0]   h_q;

  // divider
  logic [34:0] rem_q, dvs_q;
  logic [32:0] quo_q;

  // ratio, search, bound
  logic [17:0] k_q, d_q;
  logic [35:0] num_q;
  logic [34:0] den_q;
  logic [31:0] lo_q, hi_q, mid_q, acc_q, base_q;
  logic [8:0]  nsh_q;
  logic        ok_q;
  logic [25:0] cn_q;
  logic [26:0] bound_q;
  logic [23:0] hp_q;
  logic        adm_q;
  logic [24:0] margin_q;

  // combinational helpers
  logic [16:0] c_eff;
  logic [15:0] p_eff;
  logic [8:0]  n_val;
  logic [15:0] tmin;
  logic [32:0] pc;
  logic [33:0] a_sum;
  logic [35:0] div_sh, div_diff;
  logic        div_ge;
  logic [17:0] m_val, k_val, d_val;
  logic [35:0] two_den;
  logic [32:0] lohi;
  logic [56:0] prod;
  logic [24:0] newsum, hsum_new;
  logic signed [27:0] mdiff;
  logic [24:0] usum_add, hsum_add;

  assign c_eff   = (cap_q > prat_pkg::ONE_Q) ? prat_pkg::ONE_Q : cap_q;
  assign p_eff   = (period_q == 16'd0) ? 16'd1 : period_q;
  assign n_val   = {1'b0, count_q} + 9'd1;
  assign tmin    = (tp_q < minp_q) ? tp_q : minp_q;
  assign pc      = p_eff * c_eff;
  assign a_sum   = {2'b00, tmin, 16'h0000} + {1'b0, pc} + {2'b00, p_eff, 16'h0000} - 34'd1;
  assign div_sh  = {rem_q, quo_q[32]};
  assign div_ge  = div_sh >= {1'b0, dvs_q};
  assign div_diff = div_sh - {1'b0, dvs_q};
  assign m_val   = quo_q[17:0];
  assign k_val   = (m_val > 18'd2) ? (m_val - 18'd2) : 18'd0;
  assign d_val   = {prat_pkg::ONE_Q - c_eff, 1'b0};
  assign two_den = {den_q, 1'b0};
  assign lohi    = {1'b0, lo_q} + {1'b0, hi_q};
  assign prod    = cn_q * 31'(lo_q - prat_pkg::IONE);
  assign newsum  = {1'b0, usum_q} + {8'h00, u_q};
  assign hsum_new = {1'b0, hsum_q} + {1'b0, hp_q};
  assign mdiff   = $signed({1'b0, bound_q}) - $signed({3'b000, newsum});
  assign usum_add = {1'b0, usum_q} + {8'h00, u_q};
  assign hsum_add = {1'b0, hsum_q} + (harm_q ? {1'b0, hp_q} : {8'h00, u_q});

  assign status_o.op          = op_q;
  assign status_o.harm        = harm_q;
  assign status_o.ratio_bad   = (k_q == '0) && (d_q == '0);
  assign status_o.search_done = (hi_q - lo_q) <= 32'd1;
  assign status_o.pow_done    = (nsh_q == '0);
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  // control state: configuration, task state, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= 16'd1;
      cap_q       <= '0;
      count_q     <= '0;
      minp_q      <= prat_pkg::PERIOD_NONE;
      usum_q      <= '0;
      hsum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == prat_pkg::CFG_PERIOD) period_q <= cfg_data_i[15:0];
        else if (cfg_index_i == prat_pkg::CFG_CAPACITY) cap_q <= cfg_data_i;
      end
      if (ctrl_i.cmd == prat_pkg::CMD_UPDATE) begin
        if (op_q == prat_pkg::OP_ASSIGN && count_q < prat_pkg::TASK_LIMIT) begin
          count_q <= count_q + 8'd1;
          usum_q  <= usum_add[24] ? prat_pkg::SUM_MAX : usum_add[23:0];
          hsum_q  <= hsum_add[24] ? prat_pkg::SUM_MAX : hsum_add[23:0];
          if (tp_q < minp_q) minp_q <= tp_q;
        end else if (op_q == prat_pkg::OP_CLEAR) begin
          count_q <= '0;
          minp_q  <= prat_pkg::PERIOD_NONE;
          usum_q  <= '0;
          hsum_q  <= '0;
        end
      end
      if (ctrl_i.res_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.cmd)
      prat_pkg::CMD_NONE: begin
      end
      prat_pkg::CMD_LOAD: begin
        op_q   <= prat_pkg::op_e'(operation_i);
        harm_q <= harmonic_mode_i;
        tp_q   <= task_period_i;
        u_q    <= task_utilization_i;
        h_q    <= harmonicity_i;
      end
      prat_pkg::CMD_K_SETUP: begin
        // ceil(a/b) with b = P<<16 reduces to a 18-bit by 16-bit division
        rem_q <= '0;
        quo_q <= {a_sum[33:16], 15'h0000};
        dvs_q <= {19'h0, p_eff};
        ok_q  <= 1'b1;
      end
      prat_pkg::CMD_DIV_STEP: begin
        rem_q <= div_ge ? div_diff[34:0] : div_sh[34:0];
        quo_q <= {quo_q[31:0], div_ge};
      end
      prat_pkg::CMD_R_SETUP: begin
        k_q   <= k_val;
        d_q   <= d_val;
        num_q <= {1'b0, k_val, 17'h0_0000} + {18'h0, d_val};
        den_q <= {1'b0, k_val, 16'h0000} + {17'h0, d_val};
      end
      prat_pkg::CMD_R_INT: begin
        // integer part of the ratio is 1 or 2
        if (num_q >= two_den) begin
          rem_q <= 35'(num_q - two_den);
          quo_q <= 33'd2;
        end else begin
          rem_q <= 35'(num_q - {1'b0, den_q});
          quo_q <= 33'd1;
        end
        dvs_q   <= den_q;
        lo_q    <= prat_pkg::IONE;
        hi_q    <= prat_pkg::HI_INIT;
        bound_q <= '0;
        if ((k_q == '0) && (d_q == '0)) ok_q <= 1'b0;
      end
      prat_pkg::CMD_S_INIT: begin
        mid_q  <= lohi[32:1];
        acc_q  <= prat_pkg::IONE;
        base_q <= lohi[32:1];
        nsh_q  <= n_val;
      end
      prat_pkg::CMD_POW_STEP: begin
        if (nsh_q[0]) acc_q <= qmul(acc_q, base_q);
        base_q <= qmul(base_q, base_q);
        nsh_q  <= {1'b0, nsh_q[8:1]};
      end
      prat_pkg::CMD_S_UPD: begin
        // ratio sits in the low quotient bits, untouched during the search
        if (acc_q <= quo_q[31:0]) lo_q <= mid_q;
        else hi_q <= mid_q;
      end
      prat_pkg::CMD_B_MUL1: cn_q <= c_eff * n_val;
      prat_pkg::CMD_B_MUL2: bound_q <= prod[56:30];
      prat_pkg::CMD_FIN: begin
        if (harm_q) begin
          adm_q    <= hsum_new <= {8'h00, c_eff};
          margin_q <= '0;
        end else begin
          adm_q <= ok_q && ({2'b00, newsum} <= bound_q);
          if (mdiff < -28'sd16777216) margin_q <= 25'h100_0000;
          else if (mdiff > 28'sd16777215) margin_q <= 25'h0FF_FFFF;
          else margin_q <= mdiff[24:0];
        end
      end
      prat_pkg::CMD_H_SETUP: begin
        rem_q <= '0;
        quo_q <= {u_q, 16'h0000};
        dvs_q <= {17'h0, h_q};
      end
      prat_pkg::CMD_H_FIN: begin
        if (h_q == '0 || quo_q[32:24] != '0) hp_q <= prat_pkg::SUM_MAX;
        else hp_q <= quo_q[23:0];
      end
      prat_pkg::CMD_UPDATE: begin
        adm_q    <= 1'b0;
        margin_q <= '0;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_load) begin
      admitted_o        <= adm_q;
      bound_margin_o    <= $signed(margin_q);
      task_count_o      <= count_q;
      min_period_o      <= minp_q;
      utilization_sum_o <= usum_q;
      harmonic_sum_o    <= hsum_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/prat_sva.sv
// ----------------------------------------------------------------------------
// prat_sva
// Port-level checks of the admission block, bound to the top level.
// ----------------------------------------------------------------------------
`include "periodic_resource_admission_test_assert.svh"

module prat_sva (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [1:0]          cfg_index_i,
  input logic [16:0]         cfg_data_i,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic [1:0]          operation_i,
  input logic                harmonic_mode_i,
  input logic [15:0]         task_period_i,
  input logic [16:0]         task_utilization_i,
  input logic [17:0]         harmonicity_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic                admitted_o,
  input logic signed [24:0]  bound_margin_o,
  input logic [7:0]          task_count_o,
  input logic [15:0]         min_period_o,
  input logic [23:0]         utilization_sum_o,
  input logic [23:0]         harmonic_sum_o
);

  // an accepted item keeps the block busy in the next cycle
  `PRAT_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // a stalled result stays valid
  `PRAT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // an admitted task never shows a negative margin
  `PRAT_ASSERT_IMP(a_admit_margin, clk_i, rst_ni, out_valid_o && admitted_o, !bound_margin_o[24])

  // an empty task set shows cleared sums and no minimum period
  `PRAT_ASSERT_IMP(a_empty_state, clk_i, rst_ni, out_valid_o && task_count_o == 8'd0, utilization_sum_o == 24'd0 && harmonic_sum_o == 24'd0 && min_period_o == 16'hFFFF)

endmodule

bind periodic_resource_admission_test prat_sva u_prat_sva (.*);

### tb/sv/tb_periodic_resource_admission_test.sv
// ----------------------------------------------------------------------------
// tb_periodic_resource_admission_test
// Self-checking bench for the periodic resource admission unit: a queue-fed
// driver, a monitor holding a bit-exact admission predictor, and phases over
// several resource settings with random idle and stall on both sides.
// ----------------------------------------------------------------------------
module tb_periodic_resource_admission_test;

  typedef struct packed {
    prat_pkg::op_e op;
    logic          hm;
    logic [15:0]   tp;
    logic [16:0]   u;
    logic [17:0]   h;
  } task_item_t;

  typedef struct packed {
    logic               adm;
    logic signed [24:0] margin;
    logic [7:0]         cnt;
    logic [15:0]        minp;
    logic [23:0]        usum;
    logic [23:0]        hsum;
  } admit_result_t;

  localparam int HANG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [1:0] operation = '0;
  logic harmonic_mode = 1'b0;
  logic [15:0] task_period = '0;
  logic [16:0] task_util = '0;
  logic [17:0] harmonicity = '0;
  logic out_stall = 1'b0;

  logic cfg_ready, in_stall, out_valid, admitted;
  logic signed [24:0] bound_margin;
  logic [7:0] task_count;
  logic [15:0] min_period;
  logic [23:0] util_sum, harm_sum;

  task_item_t    pending_items[$];
  admit_result_t expected_results[$];
  int  idle_pct = 8;
  bit  failed = 1'b0;
  int  hang_cnt = 0;

  // predictor copy of the block's state and registers
  logic [63:0] sh_period = 64'd1, sh_capacity = 64'd0;
  logic [63:0] sh_count = 0, sh_minp = 64'd65535, sh_usum = 0, sh_hsum = 0;

  periodic_resource_admission_test dut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .operation_i(operation), .harmonic_mode_i(harmonic_mode),
    .task_period_i(task_period), .task_utilization_i(task_util),
    .harmonicity_i(harmonicity),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .admitted_o(admitted), .bound_margin_o(bound_margin),
    .task_count_o(task_count), .min_period_o(min_period),
    .utilization_sum_o(util_sum), .harmonic_sum_o(harm_sum)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] q30_mul(logic [63:0] a, logic [63:0] b);
    logic [63:0] p;
    p = (a * b) >> prat_pkg::IBITS;
    return (p > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p;
  endfunction

  function automatic logic [63:0] q30_pow(logic [63:0] x, logic [63:0] n);
    logic [63:0] acc, base;
    acc = 64'(prat_pkg::IONE);
    base = x;
    while (n != 0) begin
      if (n[0]) acc = q30_mul(acc, base);
      base = q30_mul(base, base);
      n = n >> 1;
    end
    return acc;
  endfunction

  function automatic logic [63:0] harm_share(logic [63:0] u, logic [63:0] h);
    logic [63:0] q;
    if (h == 0) return 64'(prat_pkg::SUM_MAX);
    q = (u << prat_pkg::FRAC_BITS) / h;
    return (q > 64'(prat_pkg::SUM_MAX)) ? 64'(prat_pkg::SUM_MAX) : q;
  endfunction

  function automatic logic [63:0] sat24(logic [63:0] v);
    return (v > 64'(prat_pkg::SUM_MAX)) ? 64'(prat_pkg::SUM_MAX) : v;
  endfunction

  // works out the result of one item and advances the shadow state
  function automatic admit_result_t predict_admission(task_item_t it);
    logic [63:0] c, p, u, tmin, a, b, m, k, d, newsum, bnd, num, den;
    logic [63:0] r, rem, lo, hi, mid, n;
    longint marg;
    admit_result_t res;
    c = (sh_capacity > 64'(prat_pkg::ONE_Q)) ? 64'(prat_pkg::ONE_Q) : sh_capacity;
    p = (sh_period == 0) ? 64'd1 : sh_period;
    u = 64'(it.u);
    res.adm = 1'b0;
    marg = 0;
    case (it.op)
      prat_pkg::OP_CHECK: begin
        if (it.hm) begin
          res.adm = (sh_hsum + harm_share(u, 64'(it.h)) <= c);
        end else begin
          tmin = (64'(it.tp) < sh_minp) ? 64'(it.tp) : sh_minp;
          a = tmin * 64'(prat_pkg::ONE_Q) + p * c;
          b = p * 64'(prat_pkg::ONE_Q);
          m = (a + b - 1) / b;
          k = (m > 2) ? m - 2 : 64'd0;
          d = 2 * (64'(prat_pkg::ONE_Q) - c);
          newsum = sh_usum + u;
          bnd = 0;
          // full capacity with K zero: ratio undefined, always reject
          if (!(k == 0 && d == 0)) begin
            num = 2 * k * 64'(prat_pkg::ONE_Q) + d;
            den = k * 64'(prat_pkg::ONE_Q) + d;
            r = num / den;
            rem = num % den;
            for (int i = 0; i < prat_pkg::IBITS; i++) begin
              rem = rem << 1;
              r = r << 1;
              if (rem >= den) begin
                rem = rem - den;
                r[0] = 1'b1;
              end
            end
            lo = 64'(prat_pkg::IONE);
            hi = 2 * 64'(prat_pkg::IONE) + 1;
            n = sh_count + 1;
            while (hi - lo > 1) begin
              mid = (lo + hi) >> 1;
              if (q30_pow(mid, n) <= r) lo = mid;
              else hi = mid;
            end
            bnd = (c * n * (lo - 64'(prat_pkg::IONE))) >> prat_pkg::IBITS;
            res.adm = (newsum <= bnd);
          end
          marg = longint'(bnd) - longint'(newsum);
          if (marg < -16777216) marg = -16777216;
          if (marg > 16777215) marg = 16777215;
        end
      end
      prat_pkg::OP_ASSIGN: begin
        if (sh_count < 64'(prat_pkg::TASK_LIMIT)) begin
          sh_count = sh_count + 1;
          sh_usum = sat24(sh_usum + u);
          sh_hsum = sat24(sh_hsum + (it.hm ? harm_share(u, 64'(it.h)) : u));
          if (64'(it.tp) < sh_minp) sh_minp = 64'(it.tp);
        end
      end
      prat_pkg::OP_CLEAR: begin
        sh_count = 0;
        sh_minp = 64'(prat_pkg::PERIOD_NONE);
        sh_usum = 0;
        sh_hsum = 0;
      end
      default: ;
    endcase
    res.margin = marg[24:0];
    res.cnt = sh_count[7:0];
    res.minp = sh_minp[15:0];
    res.usum = sh_usum[23:0];
    res.hsum = sh_hsum[23:0];
    return res;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!in_valid || !in_stall) begin
      if (rst_ni && pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        task_item_t it;
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        operation <= it.op;
        harmonic_mode <= it.hm;
        task_period <= it.tp;
        task_util <= it.u;
        harmonicity <= it.h;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_ni && ($urandom_range(99) < idle_pct);
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) hang_cnt <= 0;
      else hang_cnt <= hang_cnt + 1;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == prat_pkg::CFG_PERIOD) sh_period = 64'(cfg_data[15:0]);
        else if (cfg_index == prat_pkg::CFG_CAPACITY) sh_capacity = 64'(cfg_data);
      end
      if (in_valid && !in_stall) begin
        task_item_t it;
        it.op = prat_pkg::op_e'(operation);
        it.hm = harmonic_mode;
        it.tp = task_period;
        it.u = task_util;
        it.h = harmonicity;
        expected_results.insert(expected_results.size(), predict_admission(it));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no expectation waiting");
          failed = 1'b1;
        end else begin
          admit_result_t e;
          e = expected_results.pop_front();
          check_field("admitted", e.adm, admitted);
          check_field("bound_margin", e.margin, bound_margin);
          check_field("task_count", e.cnt, task_count);
          check_field("min_period", e.minp, min_period);
          check_field("utilization_sum", e.usum, util_sum);
          check_field("harmonic_sum", e.hsum, harm_sum);
        end
      end
      if (hang_cnt >= HANG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic add_item(prat_pkg::op_e op, logic hm, logic [15:0] tp, logic [16:0] u,
                          logic [17:0] h);
    task_item_t it;
    it.op = op;
    it.hm = hm;
    it.tp = tp;
    it.u = u;
    it.h = h;
    pending_items.insert(pending_items.size(), it);
  endtask

  // assign_pct: share of assigns; clears are rare so the count can fill up
  task automatic add_random_items(int num, int assign_pct, int clear_pct);
    int sel;
    logic [15:0] tp;
    logic [16:0] u;
    logic [17:0] h;
    prat_pkg::op_e op;
    for (int i = 0; i < num; i++) begin
      sel = $urandom_range(99);
      if (sel < clear_pct) op = prat_pkg::OP_CLEAR;
      else if (sel < clear_pct + 4) op = prat_pkg::OP_NOP;
      else if (sel < clear_pct + 4 + assign_pct) op = prat_pkg::OP_ASSIGN;
      else op = prat_pkg::OP_CHECK;
      case ($urandom_range(9))
        0: tp = 16'd0;
        1: tp = 16'hFFFF;
        2, 3, 4, 5: tp = 16'($urandom_range(1, 200));
        default: tp = 16'($urandom);
      endcase
      case ($urandom_range(9))
        0: u = 17'd0;
        1: u = 17'(prat_pkg::ONE_Q);
        2: u = 17'($urandom);
        default: u = 17'($urandom_range(0, 4000));
      endcase
      case ($urandom_range(19))
        0: h = 18'd0;
        1: h = 18'($urandom);
        default: h = 18'($urandom_range(32768, 262143));
      endcase
      add_item(op, 1'($urandom_range(1)), tp, u, h);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(prat_pkg::CFG_PERIOD, 17'd10);
    write_reg(prat_pkg::CFG_CAPACITY, 17'd32768);
    add_item(prat_pkg::OP_CHECK, 1'b0, 16'd100, 17'd1000, 18'd65536);
    add_item(prat_pkg::OP_CHECK, 1'b1, 16'd100, 17'd1000, 18'd65536);
    add_item(prat_pkg::OP_ASSIGN, 1'b0, 16'd50, 17'd0, 18'd65536);
    add_item(prat_pkg::OP_ASSIGN, 1'b1, 16'd200, 17'd65536, 18'd1);
    add_item(prat_pkg::OP_ASSIGN, 1'b1, 16'd300, 17'd4000, 18'd0);  // zero harmonicity
    add_item(prat_pkg::OP_CHECK, 1'b0, 16'd65535, 17'd131071, 18'd262143);
    add_item(prat_pkg::OP_ASSIGN, 1'b0, 16'd0, 17'd2000, 18'd65536);  // zero period
    add_item(prat_pkg::OP_CHECK, 1'b0, 16'd1, 17'd10, 18'd65536);
    add_item(prat_pkg::OP_CHECK, 1'b1, 16'd1, 17'd0, 18'd262143);
    add_item(prat_pkg::OP_NOP, 1'b1, 16'hFFFF, 17'h1FFFF, 18'h3FFFF);
    add_item(prat_pkg::OP_CLEAR, 1'b0, 16'd1, 17'd0, 18'd1);
    add_item(prat_pkg::OP_CHECK, 1'b0, 16'd65535, 17'd0, 18'd1);
    add_item(prat_pkg::OP_ASSIGN, 1'b1, 16'd0, 17'h1FFFF, 18'd1);
    add_item(prat_pkg::OP_CHECK, 1'b1, 16'd5, 17'd1, 18'd1);
    add_random_items(170, 40, 5);
    // sender holds off here until every result is back
    wait_drain();

    write_reg(prat_pkg::CFG_PERIOD, 17'd65535);
    write_reg(prat_pkg::CFG_CAPACITY, 17'(prat_pkg::ONE_Q));  // full capacity, K zero
    add_random_items(150, 40, 5);
    wait_drain();

    idle_pct = 0;
    write_reg(prat_pkg::CFG_PERIOD, 17'd1);
    write_reg(prat_pkg::CFG_CAPACITY, 17'd0);
    add_random_items(150, 40, 5);
    wait_drain();
    idle_pct = 8;

    write_reg(prat_pkg::CFG_PERIOD, 17'd0);  // zero period
    write_reg(prat_pkg::CFG_CAPACITY, 17'd40000);
    add_random_items(330, 85, 0);  // fills the task count to its limit
    wait_drain();

    write_reg(prat_pkg::CFG_PERIOD, 17'd7);
    write_reg(prat_pkg::CFG_CAPACITY, 17'h1FFFF);  // capacity above one
    add_random_items(170, 40, 5);
    wait_drain();

    write_reg(prat_pkg::CFG_PERIOD, 17'($urandom_range(1, 65535)));
    write_reg(prat_pkg::CFG_CAPACITY, 17'($urandom_range(0, 65536)));
    add_random_items(170, 40, 5);
    wait_drain();

    repeat (500) @(posedge clk_i);
    if (!failed && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
